// File: design/bms_pkg.sv
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types and constants of the byte merge sort unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bms_pkg;

  // Run capacity and derived widths
  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int SUM_W   = CNT_W + 1;

  localparam int VALUE_W = 8;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [VALUE_W-1:0] byte_t;

  // Controller states
  typedef enum logic [2:0] {
    S_LOAD,
    S_PASS,
    S_SPAN,
    S_RD,
    S_WR,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_HOLD
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // input item accepted
    logic sort_init;  // start of sort: first pass, span at 0
    logic span_init;  // set up next span of the pass
    logic pass_next;  // pass finished: swap buffers, double width
    logic merge_wr;   // write one merged byte
    logic emit_init;  // start reading the sorted run
    logic emit_ld;    // load output register
    logic emit_next;  // output taken, step to next byte
    logic run_clr;    // clear count and drop flag
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pass_more;  // width below run length
    logic span_more;  // span start below run length
    logic span_end;   // current write is the last of the span
    logic emit_last;  // current emit byte is the last of the run
  } sts_t;

endpackage

`default_nettype wire

// File: design/bms_in_if.sv
// ----------------------------------------------------------------------------
// bms_in_if
// Input channel: one byte of the run per item, with a last marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface bms_in_if
  import bms_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

// File: design/bms_out_if.sv
// ----------------------------------------------------------------------------
// bms_out_if
// Result channel: one sorted byte per item with run end and overflow flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface bms_out_if
  import bms_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t sorted_value;
  logic  end_of_run;
  logic  overflow;

  modport source (output valid, output sorted_value, output end_of_run,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input end_of_run,
                  input overflow, output ready);
endinterface

`default_nettype wire

// File: design/byte_merge_sort_unit.sv
// ----------------------------------------------------------------------------
// byte_merge_sort_unit
// Collects a run of bytes, sorts it ascending by merge sort, emits it.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one byte per item; last marks the end of the run. Bytes
//          past 64 in a run are dropped and the run's results flag overflow.
//   out_ch returns the run in ascending order, one byte per item, with
//          end_of_run on the final byte. Equal keys keep right-before-left
//          order of the merge halves.
// Timing:
//   Loading accepts one byte per cycle. After the last item the sort runs
//   ceil(log2(n)) passes of bottom-up merging, with a read state and a write
//   state per byte through the two buffer memories. Each byte is emitted
//   through a read, a load and a hold state; the hold waits for out_ch.ready.
//   No new input is accepted until the whole run has been delivered.
// Reset:
//   Synchronous, active low; clears the run length, drop flag, pointers and
//   controller. Buffer contents are not cleared.
// Stall:
//   A result waits in the output register, unchanged, until out_ch.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_merge_sort_unit
  import bms_pkg::*;
(
  input wire         clk,
  input wire         rst_n,
  bms_in_if.sink     in_ch,
  bms_out_if.source  out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  // Sequencer
  bms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Buffers and pointers
  bms_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_value         (in_ch.value),
    .sts              (sts),
    .out_sorted_value (out_ch.sorted_value),
    .out_end_of_run   (out_ch.end_of_run),
    .out_overflow     (out_ch.overflow)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

// File: design/bms_ctrl.sv
// ----------------------------------------------------------------------------
// bms_ctrl
// Sequencer: load, bottom-up merge passes, and byte-by-byte emission.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_ctrl
  import bms_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  input  wire       in_last,
  input  wire       out_ready,
  input  wire sts_t sts,
  output logic      in_ready,
  output logic      out_valid,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.sort_init = 1'b1;
            state_nxt     = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (sts.pass_more) begin
          state_nxt = S_SPAN;
        end else begin
          cmd.emit_init = 1'b1;
          state_nxt     = S_EMIT_RD;
        end
      end
      S_SPAN: begin
        if (sts.span_more) begin
          cmd.span_init = 1'b1;
          state_nxt     = S_RD;
        end else begin
          cmd.pass_next = 1'b1;
          state_nxt     = S_PASS;
        end
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.merge_wr = 1'b1;
        state_nxt    = sts.span_end ? S_SPAN : S_RD;
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_nxt   = S_EMIT_HOLD;
      end
      S_EMIT_HOLD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.emit_last) begin
            cmd.run_clr = 1'b1;
            state_nxt   = S_LOAD;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/bms_datapath.sv
// ----------------------------------------------------------------------------
// bms_datapath
// Two byte buffers, merge pointers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_datapath
  import bms_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire cmd_t  cmd,
  input  wire byte_t in_value,
  output sts_t       sts,
  output byte_t      out_sorted_value,
  output logic       out_end_of_run,
  output logic       out_overflow
);

  // Buffers: mem0 is the run buffer, mem1 the scratch buffer
  byte_t mem0 [MAX_LEN];
  byte_t mem1 [MAX_LEN];

  cnt_t  count_r;
  logic  dropped_r;
  cnt_t  w_r, lo_r, mid_r, hi_r, a_r, b_r, o_r;
  logic  src_sel_r;   // 0: read mem0, write mem1
  byte_t rd0a_r, rd0b_r, rd1a_r, rd1b_r;
  byte_t out_value_r;
  logic  out_end_r, out_ovf_r;

  logic  full;
  logic  [SUM_W-1:0] mid_sum, hi_sum;
  cnt_t  mid_new, hi_new;
  byte_t src_a, src_b;
  logic  take_a;
  byte_t merge_val;
  cnt_t  a_inc;

  assign full = (count_r >= cnt_t'(MAX_LEN));

  // Span bounds clipped to run length
  assign mid_sum = {1'b0, lo_r} + {1'b0, w_r};
  assign hi_sum  = {1'b0, lo_r} + {w_r, 1'b0};
  assign mid_new = (mid_sum > {1'b0, count_r}) ? count_r : mid_sum[CNT_W-1:0];
  assign hi_new  = (hi_sum  > {1'b0, count_r}) ? count_r : hi_sum[CNT_W-1:0];

  // Merge choice; equal keys take the right-hand element
  assign src_a     = src_sel_r ? rd1a_r : rd0a_r;
  assign src_b     = src_sel_r ? rd1b_r : rd0b_r;
  assign take_a    = (a_r < mid_r) && ((b_r >= hi_r) || (src_a < src_b));
  assign merge_val = take_a ? src_a : src_b;
  assign a_inc     = a_r + cnt_t'(1);

  // Status
  assign sts.pass_more = (w_r < count_r);
  assign sts.span_more = (lo_r < count_r);
  assign sts.span_end  = ((o_r + cnt_t'(1)) == hi_r);
  assign sts.emit_last = (a_inc == count_r);

  // Run buffer: loaded from input, or merge target on odd passes
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem0[count_r[ADDR_W-1:0]] <= in_value;
    end else if (cmd.merge_wr && src_sel_r) begin
      mem0[o_r[ADDR_W-1:0]] <= merge_val;
    end
    rd0a_r <= mem0[a_r[ADDR_W-1:0]];
    rd0b_r <= mem0[b_r[ADDR_W-1:0]];
  end

  // Scratch buffer: merge target on even passes
  always_ff @(posedge clk) begin
    if (cmd.merge_wr && !src_sel_r) begin
      mem1[o_r[ADDR_W-1:0]] <= merge_val;
    end
    rd1a_r <= mem1[a_r[ADDR_W-1:0]];
    rd1b_r <= mem1[b_r[ADDR_W-1:0]];
  end

  // Run length and drop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.run_clr) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        dropped_r <= 1'b1;
      end else begin
        count_r <= count_r + cnt_t'(1);
      end
    end
  end

  // Pass and span pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_sel_r <= 1'b0;
      w_r       <= '0;
      lo_r      <= '0;
      mid_r     <= '0;
      hi_r      <= '0;
      a_r       <= '0;
      b_r       <= '0;
      o_r       <= '0;
    end else begin
      if (cmd.sort_init) begin
        src_sel_r <= 1'b0;
        w_r       <= cnt_t'(1);
        lo_r      <= '0;
      end
      if (cmd.pass_next) begin
        src_sel_r <= ~src_sel_r;
        w_r       <= {w_r[CNT_W-2:0], 1'b0};
        lo_r      <= '0;
      end
      if (cmd.span_init) begin
        mid_r <= mid_new;
        hi_r  <= hi_new;
        a_r   <= lo_r;
        b_r   <= mid_new;
        o_r   <= lo_r;
      end
      if (cmd.merge_wr) begin
        o_r <= o_r + cnt_t'(1);
        if (take_a) begin
          a_r <= a_inc;
        end else begin
          b_r <= b_r + cnt_t'(1);
        end
        if (sts.span_end) begin
          lo_r <= hi_r;
        end
      end
      if (cmd.emit_init) begin
        a_r <= '0;
      end
      if (cmd.emit_next) begin
        a_r <= a_inc;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_value_r <= src_a;
      out_end_r   <= sts.emit_last;
      out_ovf_r   <= dropped_r;
    end
  end

  assign out_sorted_value = out_value_r;
  assign out_end_of_run   = out_end_r;
  assign out_overflow     = out_ovf_r;

endmodule

`default_nettype wire
